FILE: rtl/tcls_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcls_pkg
// Shared widths, latencies, types and helpers for the tripod load split.
// ----------------------------------------------------------------------------
package tcls_pkg;

    localparam int COORD_BITS = 20;
    localparam int LOAD_BITS  = 32;
    localparam int WEIGHT_W   = 20;

    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = WEIGHT_W'(30000);

    localparam int OFS_W  = COORD_BITS + 1;
    localparam int PROD_W = 2 * OFS_W;
    localparam int COF_W  = PROD_W + 1;
    localparam int DET_W  = COF_W + 2;
    localparam int NUM_W  = WEIGHT_W + COF_W;
    localparam int SHD_W  = DET_W + LOAD_BITS;
    localparam int CMP_W  = (NUM_W > SHD_W) ? NUM_W : SHD_W;

    localparam int FRONT_LAT = 5;
    localparam int LANE_LAT  = LOAD_BITS + 2;
    localparam int TOTAL_LAT = FRONT_LAT + LANE_LAT + 1;

    typedef struct packed {
        logic                 valid;
        logic                 singular;
        logic [2:0]           neg;
        logic [NUM_W-1:0]     num_a;
        logic [NUM_W-1:0]     num_b;
        logic [NUM_W-1:0]     num_c;
        logic [DET_W-1:0]     den;
    } front_word_t;

    typedef struct packed {
        logic valid;
        logic singular;
    } tag_t;

    function automatic logic signed [PROD_W-1:0] mul_s(
        input logic signed [OFS_W-1:0] a,
        input logic signed [OFS_W-1:0] b
    );
        logic signed [PROD_W-1:0] ax;
        logic signed [PROD_W-1:0] bx;
        ax = PROD_W'(a);
        bx = PROD_W'(b);
        return ax * bx;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/tcls_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcls_front
// Five-stage front end: offsets, cross products, cofactors, determinant,
// magnitudes and weighted numerators.
// ----------------------------------------------------------------------------
module tcls_front (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   in_valid,
    input  wire logic signed [tcls_pkg::COORD_BITS-1:0] foot_a_x,
    input  wire logic signed [tcls_pkg::COORD_BITS-1:0] foot_a_y,
    input  wire logic signed [tcls_pkg::COORD_BITS-1:0] foot_b_x,
    input  wire logic signed [tcls_pkg::COORD_BITS-1:0] foot_b_y,
    input  wire logic signed [tcls_pkg::COORD_BITS-1:0] foot_c_x,
    input  wire logic signed [tcls_pkg::COORD_BITS-1:0] foot_c_y,
    input  wire logic signed [tcls_pkg::COORD_BITS-1:0] mass_center_x,
    input  wire logic signed [tcls_pkg::COORD_BITS-1:0] mass_center_y,
    input  wire logic        [tcls_pkg::WEIGHT_W-1:0]   weight,
    output tcls_pkg::front_word_t                       word
);

    localparam int OFS_W  = tcls_pkg::OFS_W;
    localparam int PROD_W = tcls_pkg::PROD_W;
    localparam int COF_W  = tcls_pkg::COF_W;
    localparam int DET_W  = tcls_pkg::DET_W;
    localparam int NUM_W  = tcls_pkg::NUM_W;

    logic [4:0] valid_reg;
    logic [4:0] valid_next;

    // stage 1
    logic signed [OFS_W-1:0]  dx_reg  [3];
    logic signed [OFS_W-1:0]  dy_reg  [3];
    logic signed [OFS_W-1:0]  dx_next [3];
    logic signed [OFS_W-1:0]  dy_next [3];
    // stage 2
    logic signed [PROD_W-1:0] prod_reg  [6];
    logic signed [PROD_W-1:0] prod_next [6];
    // stage 3
    logic signed [COF_W-1:0]  cof_reg  [3];
    logic signed [COF_W-1:0]  cof_next [3];
    // stage 4
    logic signed [DET_W-1:0]  det_reg;
    logic signed [DET_W-1:0]  det_next;
    logic        [COF_W-1:0]  cmag_reg  [3];
    logic        [COF_W-1:0]  cmag_next [3];
    logic        [2:0]        cneg_reg;
    logic        [2:0]        cneg_next;
    // stage 5
    logic                     singular_reg;
    logic                     singular_next;
    logic        [2:0]        neg_reg;
    logic        [2:0]        neg_next;
    logic        [DET_W-1:0]  den_reg;
    logic        [DET_W-1:0]  den_next;
    logic        [NUM_W-1:0]  num_reg  [3];
    logic        [NUM_W-1:0]  num_next [3];

    logic        [DET_W-1:0]  det_raw;
    logic        [COF_W-1:0]  cof_raw [3];

    always_comb
    begin
        valid_next = {valid_reg[3:0], in_valid};

        dx_next[0] = OFS_W'(foot_a_x) - OFS_W'(mass_center_x);
        dx_next[1] = OFS_W'(foot_b_x) - OFS_W'(mass_center_x);
        dx_next[2] = OFS_W'(foot_c_x) - OFS_W'(mass_center_x);
        dy_next[0] = OFS_W'(foot_a_y) - OFS_W'(mass_center_y);
        dy_next[1] = OFS_W'(foot_b_y) - OFS_W'(mass_center_y);
        dy_next[2] = OFS_W'(foot_c_y) - OFS_W'(mass_center_y);

        prod_next[0] = tcls_pkg::mul_s(dx_reg[1], dy_reg[2]);
        prod_next[1] = tcls_pkg::mul_s(dx_reg[2], dy_reg[1]);
        prod_next[2] = tcls_pkg::mul_s(dx_reg[2], dy_reg[0]);
        prod_next[3] = tcls_pkg::mul_s(dx_reg[0], dy_reg[2]);
        prod_next[4] = tcls_pkg::mul_s(dx_reg[0], dy_reg[1]);
        prod_next[5] = tcls_pkg::mul_s(dx_reg[1], dy_reg[0]);

        cof_next[0] = COF_W'(prod_reg[0]) - COF_W'(prod_reg[1]);
        cof_next[1] = COF_W'(prod_reg[2]) - COF_W'(prod_reg[3]);
        cof_next[2] = COF_W'(prod_reg[4]) - COF_W'(prod_reg[5]);

        det_next = DET_W'(cof_reg[0]) + DET_W'(cof_reg[1]) + DET_W'(cof_reg[2]);
        for (int i = 0; i < 3; i++)
        begin
            cof_raw[i]   = cof_reg[i];
            cneg_next[i] = cof_raw[i][COF_W-1];
            cmag_next[i] = cof_raw[i][COF_W-1] ? (COF_W'(0) - cof_raw[i]) : cof_raw[i];
        end

        det_raw       = det_reg;
        singular_next = (det_raw == DET_W'(0));
        den_next      = det_raw[DET_W-1] ? (DET_W'(0) - det_raw) : det_raw;
        for (int i = 0; i < 3; i++)
        begin
            neg_next[i] = cneg_reg[i] ^ det_raw[DET_W-1];
            num_next[i] = NUM_W'(weight) * NUM_W'(cmag_reg[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dx_reg       <= dx_next;
        dy_reg       <= dy_next;
        prod_reg     <= prod_next;
        cof_reg      <= cof_next;
        det_reg      <= det_next;
        cmag_reg     <= cmag_next;
        cneg_reg     <= cneg_next;
        singular_reg <= singular_next;
        neg_reg      <= neg_next;
        den_reg      <= den_next;
        num_reg      <= num_next;
    end

    assign word.valid    = valid_reg[4];
    assign word.singular = singular_reg;
    assign word.neg      = neg_reg;
    assign word.num_a    = num_reg[0];
    assign word.num_b    = num_reg[1];
    assign word.num_c    = num_reg[2];
    assign word.den      = den_reg;

endmodule
`default_nettype wire

FILE: rtl/tcls_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcls_div
// Pipelined restoring divider lane: range check, one quotient bit per stage,
// then saturation and sign.
// ----------------------------------------------------------------------------
module tcls_div (
    input  wire logic                                  clk,
    input  wire logic        [tcls_pkg::NUM_W-1:0]     num,
    input  wire logic        [tcls_pkg::DET_W-1:0]     den,
    input  wire logic                                  neg,
    output logic signed      [tcls_pkg::LOAD_BITS-1:0] load,
    output logic                                       sat
);

    localparam int NUM_W = tcls_pkg::NUM_W;
    localparam int DET_W = tcls_pkg::DET_W;
    localparam int CMP_W = tcls_pkg::CMP_W;
    localparam int QW    = tcls_pkg::LOAD_BITS;

    logic [NUM_W-1:0] rem_reg [QW+1];
    logic [QW-1:0]    quo_reg [QW+1];
    logic [DET_W-1:0] den_reg [QW+1];
    logic             neg_reg [QW+1];
    logic             ovf_reg [QW+1];

    logic             ovf_next;
    logic [QW-1:0]    limit;
    logic             sat_next;
    logic [QW-1:0]    mag;
    logic [QW-1:0]    load_next;
    logic [QW-1:0]    load_reg;
    logic             sat_reg;

    // quotient wider than QW bits saturates in every case
    assign ovf_next = CMP_W'(num) >= (CMP_W'(den) << QW);

    always_ff @(posedge clk)
    begin
        rem_reg[0] <= num;
        quo_reg[0] <= '0;
        den_reg[0] <= den;
        neg_reg[0] <= neg;
        ovf_reg[0] <= ovf_next;
    end

    for (genvar k = 0; k < QW; k++)
    begin : g_step
        localparam int SH = QW - 1 - k;
        logic [CMP_W-1:0] shifted;
        logic [CMP_W-1:0] diff;
        logic             ge;
        logic [NUM_W-1:0] rem_next;
        logic [QW-1:0]    quo_next;

        always_comb
        begin
            shifted  = CMP_W'(den_reg[k]) << SH;
            diff     = CMP_W'(rem_reg[k]) - shifted;
            ge       = CMP_W'(rem_reg[k]) >= shifted;
            rem_next = ge ? diff[NUM_W-1:0] : rem_reg[k];
            quo_next = {quo_reg[k][QW-2:0], ge};
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k+1] <= rem_next;
            quo_reg[k+1] <= quo_next;
            den_reg[k+1] <= den_reg[k];
            neg_reg[k+1] <= neg_reg[k];
            ovf_reg[k+1] <= ovf_reg[k];
        end
    end

    always_comb
    begin
        limit     = {1'b0, {(QW-1){1'b1}}} + QW'(neg_reg[QW]);
        sat_next  = ovf_reg[QW] || (quo_reg[QW] > limit);
        mag       = sat_next ? limit : quo_reg[QW];
        load_next = neg_reg[QW] ? (QW'(0) - mag) : mag;
    end

    always_ff @(posedge clk)
    begin
        load_reg <= load_next;
        sat_reg  <= sat_next;
    end

    assign load = load_reg;
    assign sat  = sat_reg;

endmodule
`default_nettype wire

FILE: rtl/three_contact_load_split.sv
`default_nettype none
// ----------------------------------------------------------------------------
// three_contact_load_split
// Static vertical load split over three support feet around a CoM point.
// ----------------------------------------------------------------------------
// Fully pipelined: one word is taken in every cycle and busy never rises.
// Each word passes the front end and then the three divider lanes, which
// resolve one quotient bit per stage, before its result appears with done.
// Results are shown for one cycle only and cannot be held off. body_weight
// may be written at any time the pipeline is empty; weight_ready is always
// high.
// ----------------------------------------------------------------------------
module three_contact_load_split (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   start,
    output logic                                        busy,
    input  wire logic                                   weight_valid,
    output logic                                        weight_ready,
    input  wire logic        [tcls_pkg::WEIGHT_W-1:0]   body_weight,
    input  wire logic signed [tcls_pkg::COORD_BITS-1:0] foot_a_x,
    input  wire logic signed [tcls_pkg::COORD_BITS-1:0] foot_a_y,
    input  wire logic signed [tcls_pkg::COORD_BITS-1:0] foot_b_x,
    input  wire logic signed [tcls_pkg::COORD_BITS-1:0] foot_b_y,
    input  wire logic signed [tcls_pkg::COORD_BITS-1:0] foot_c_x,
    input  wire logic signed [tcls_pkg::COORD_BITS-1:0] foot_c_y,
    input  wire logic signed [tcls_pkg::COORD_BITS-1:0] mass_center_x,
    input  wire logic signed [tcls_pkg::COORD_BITS-1:0] mass_center_y,
    output logic                                        done,
    output logic signed      [tcls_pkg::LOAD_BITS-1:0]  load_a,
    output logic signed      [tcls_pkg::LOAD_BITS-1:0]  load_b,
    output logic signed      [tcls_pkg::LOAD_BITS-1:0]  load_c,
    output logic                                        singular,
    output logic                                        clipped
);

    localparam int QW = tcls_pkg::LOAD_BITS;
    localparam int TL = tcls_pkg::LANE_LAT;

    logic [tcls_pkg::WEIGHT_W-1:0] weight_reg;
    tcls_pkg::front_word_t         front_word;
    tcls_pkg::tag_t                tag_reg [TL];

    logic signed [QW-1:0] lane_load [3];
    logic                 lane_sat  [3];

    logic                 done_reg;
    logic signed [QW-1:0] load_a_reg;
    logic signed [QW-1:0] load_b_reg;
    logic signed [QW-1:0] load_c_reg;
    logic                 singular_reg;
    logic                 clipped_reg;

    assign busy         = 1'b0;
    assign weight_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_reg <= tcls_pkg::WEIGHT_RESET;
        end
        else if (weight_valid && weight_ready)
        begin
            weight_reg <= body_weight;
        end
    end

    tcls_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (start && !busy),
        .foot_a_x      (foot_a_x),
        .foot_a_y      (foot_a_y),
        .foot_b_x      (foot_b_x),
        .foot_b_y      (foot_b_y),
        .foot_c_x      (foot_c_x),
        .foot_c_y      (foot_c_y),
        .mass_center_x (mass_center_x),
        .mass_center_y (mass_center_y),
        .weight        (weight_reg),
        .word          (front_word)
    );

    tcls_div u_div_a (
        .clk  (clk),
        .num  (front_word.num_a),
        .den  (front_word.den),
        .neg  (front_word.neg[0]),
        .load (lane_load[0]),
        .sat  (lane_sat[0])
    );

    tcls_div u_div_b (
        .clk  (clk),
        .num  (front_word.num_b),
        .den  (front_word.den),
        .neg  (front_word.neg[1]),
        .load (lane_load[1]),
        .sat  (lane_sat[1])
    );

    tcls_div u_div_c (
        .clk  (clk),
        .num  (front_word.num_c),
        .den  (front_word.den),
        .neg  (front_word.neg[2]),
        .load (lane_load[2]),
        .sat  (lane_sat[2])
    );

    // advance valid and singular alongside the divider lanes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TL; i++)
            begin
                tag_reg[i] <= '0;
            end
        end
        else
        begin
            tag_reg[0].valid    <= front_word.valid;
            tag_reg[0].singular <= front_word.singular;
            for (int i = 1; i < TL; i++)
            begin
                tag_reg[i] <= tag_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= tag_reg[TL-1].valid;
        end
    end

    // drop the lane results when the feet are collinear
    always_ff @(posedge clk)
    begin
        singular_reg <= tag_reg[TL-1].singular;
        if (tag_reg[TL-1].singular)
        begin
            load_a_reg  <= '0;
            load_b_reg  <= '0;
            load_c_reg  <= '0;
            clipped_reg <= 1'b0;
        end
        else
        begin
            load_a_reg  <= lane_load[0];
            load_b_reg  <= lane_load[1];
            load_c_reg  <= lane_load[2];
            clipped_reg <= lane_sat[0] || lane_sat[1] || lane_sat[2];
        end
    end

    assign done     = done_reg;
    assign load_a   = load_a_reg;
    assign load_b   = load_b_reg;
    assign load_c   = load_c_reg;
    assign singular = singular_reg;
    assign clipped  = clipped_reg;

    a_fixed_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##(tcls_pkg::TOTAL_LAT) done)
        else $error("accepted word did not complete at the pipeline latency");

    a_no_spurious_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, tcls_pkg::TOTAL_LAT))
        else $error("result without a matching accepted word");

    a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && singular) |-> (load_a == '0 && load_b == '0 && load_c == '0 && !clipped))
        else $error("collinear feet produced nonzero loads or a clip flag");

endmodule
`default_nettype wire

FILE: verif/three_contact_load_split_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// three_contact_load_split_tb
// Streams tripod stances with random sender gaps through the load split
// and checks each result word against a bit-exact integer predictor:
// offsets, cofactors, truncating division and saturation. The run covers
// several body weights, from zero to full scale.
// ----------------------------------------------------------------------------

typedef struct packed {
    logic signed [tcls_pkg::COORD_BITS-1:0] ax;
    logic signed [tcls_pkg::COORD_BITS-1:0] ay;
    logic signed [tcls_pkg::COORD_BITS-1:0] bx;
    logic signed [tcls_pkg::COORD_BITS-1:0] by;
    logic signed [tcls_pkg::COORD_BITS-1:0] cx;
    logic signed [tcls_pkg::COORD_BITS-1:0] cy;
    logic signed [tcls_pkg::COORD_BITS-1:0] mx;
    logic signed [tcls_pkg::COORD_BITS-1:0] my;
} stance_t;

typedef struct packed {
    logic signed [tcls_pkg::LOAD_BITS-1:0] la;
    logic signed [tcls_pkg::LOAD_BITS-1:0] lb;
    logic signed [tcls_pkg::LOAD_BITS-1:0] lc;
    logic                                  sing;
    logic                                  clip;
} load_set_t;

class load_scoreboard;
    logic [tcls_pkg::WEIGHT_W-1:0] weight;
    load_set_t                     expected_q[$];
    int                            errors;
    int                            words;
    int                            results;
    int                            singular_cnt;
    int                            clipped_cnt;

    function new();
        weight       = tcls_pkg::WEIGHT_RESET;
        errors       = 0;
        words        = 0;
        results      = 0;
        singular_cnt = 0;
        clipped_cnt  = 0;
    endfunction

    function void flag(string msg);
        if (errors < 10)
            $display("[%0t] %s", $time, msg);
        errors++;
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    function longint offset(input logic signed [tcls_pkg::COORD_BITS-1:0] p,
                            input logic signed [tcls_pkg::COORD_BITS-1:0] ctr);
        return longint'(p) - longint'(ctr);
    endfunction

    // weight * cof / det, truncated toward zero, saturated to LOAD_BITS
    function logic signed [tcls_pkg::LOAD_BITS-1:0] foot_share(
        input longint cof,
        input longint det,
        inout bit     sat
    );
        logic [127:0] num;
        logic [127:0] den;
        logic [127:0] quo;
        logic [127:0] cap;
        bit           neg;
        neg = (cof < 0) != (det < 0);
        num = (cof < 0) ? -cof : cof;
        den = (det < 0) ? -det : det;
        num = num * weight;
        quo = num / den;
        cap = neg ? (128'd1 << (tcls_pkg::LOAD_BITS - 1))
                  : (128'd1 << (tcls_pkg::LOAD_BITS - 1)) - 128'd1;
        if (cof == 0)
            return '0;
        if (quo > cap)
        begin
            sat = 1'b1;
            quo = cap;
        end
        return neg ? -quo[tcls_pkg::LOAD_BITS-1:0] : quo[tcls_pkg::LOAD_BITS-1:0];
    endfunction

    function void note_stance(stance_t s);
        longint    dxa, dya, dxb, dyb, dxc, dyc;
        longint    c0, c1, c2, det;
        load_set_t want;
        bit        sat;
        dxa = offset(s.ax, s.mx);
        dya = offset(s.ay, s.my);
        dxb = offset(s.bx, s.mx);
        dyb = offset(s.by, s.my);
        dxc = offset(s.cx, s.mx);
        dyc = offset(s.cy, s.my);
        c0  = dxb * dyc - dxc * dyb;
        c1  = dxc * dya - dxa * dyc;
        c2  = dxa * dyb - dxb * dya;
        det = c0 + c1 + c2;
        sat = 1'b0;
        if (det == 0)
        begin
            want.la   = '0;
            want.lb   = '0;
            want.lc   = '0;
            want.sing = 1'b1;
            want.clip = 1'b0;
        end
        else
        begin
            want.la   = foot_share(c0, det, sat);
            want.lb   = foot_share(c1, det, sat);
            want.lc   = foot_share(c2, det, sat);
            want.sing = 1'b0;
            want.clip = sat;
        end
        expected_q.push_back(want);
        words++;
    endfunction

    function void check_loads(load_set_t got);
        load_set_t want;
        if (expected_q.size() == 0)
        begin
            flag($sformatf("unexpected result: a=%0d b=%0d c=%0d sing=%0b clip=%0b",
                 $signed(got.la), $signed(got.lb), $signed(got.lc), got.sing, got.clip));
            return;
        end
        want = expected_q.pop_front();
        results++;
        if (want.sing)
            singular_cnt++;
        if (want.clip)
            clipped_cnt++;
        if (got.la !== want.la || got.lb !== want.lb || got.lc !== want.lc ||
            got.sing !== want.sing || got.clip !== want.clip)
            flag($sformatf({"mismatch: expected a=%0d b=%0d c=%0d sing=%0b clip=%0b, ",
                            "got a=%0d b=%0d c=%0d sing=%0b clip=%0b"},
                 $signed(want.la), $signed(want.lb), $signed(want.lc), want.sing, want.clip,
                 $signed(got.la), $signed(got.lb), $signed(got.lc), got.sing, got.clip));
    endfunction

    function void flush_leftover();
        if (expected_q.size() != 0)
            flag($sformatf("%0d expected results never arrived", expected_q.size()));
    endfunction
endclass

module three_contact_load_split_tb;

    localparam int COORD_BITS = tcls_pkg::COORD_BITS;
    localparam int LOAD_BITS  = tcls_pkg::LOAD_BITS;
    localparam int WEIGHT_W   = tcls_pkg::WEIGHT_W;
    localparam int TOTAL_LAT  = tcls_pkg::TOTAL_LAT;
    localparam int CRD_MAX    = (1 << (COORD_BITS - 1)) - 1;
    localparam int CRD_MIN    = -(1 << (COORD_BITS - 1));
    localparam int WEIGHT_MAX = (1 << WEIGHT_W) - 1;
    localparam int QUIET_MAX  = 2000;
    localparam int SEG_WORDS  = 265;

    logic                         clk;
    logic                         rst_n;
    logic                         start;
    logic                         busy;
    logic                         weight_valid;
    logic                         weight_ready;
    logic [WEIGHT_W-1:0]          body_weight;
    logic signed [COORD_BITS-1:0] foot_a_x;
    logic signed [COORD_BITS-1:0] foot_a_y;
    logic signed [COORD_BITS-1:0] foot_b_x;
    logic signed [COORD_BITS-1:0] foot_b_y;
    logic signed [COORD_BITS-1:0] foot_c_x;
    logic signed [COORD_BITS-1:0] foot_c_y;
    logic signed [COORD_BITS-1:0] mass_center_x;
    logic signed [COORD_BITS-1:0] mass_center_y;
    logic                         done;
    logic signed [LOAD_BITS-1:0]  load_a;
    logic signed [LOAD_BITS-1:0]  load_b;
    logic signed [LOAD_BITS-1:0]  load_c;
    logic                         singular;
    logic                         clipped;

    load_scoreboard sb;
    int             idle_pct;
    int             weight_writes;
    int             quiet;

    three_contact_load_split uut (.*);

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        stance_t   s;
        load_set_t got;
        if (rst_n)
        begin
            if (weight_valid && weight_ready)
            begin
                sb.weight = body_weight;
                weight_writes++;
            end
            if (done)
            begin
                got.la   = load_a;
                got.lb   = load_b;
                got.lc   = load_c;
                got.sing = singular;
                got.clip = clipped;
                sb.check_loads(got);
            end
            if (start && !busy)
            begin
                s.ax = foot_a_x;
                s.ay = foot_a_y;
                s.bx = foot_b_x;
                s.by = foot_b_y;
                s.cx = foot_c_x;
                s.cy = foot_c_y;
                s.mx = mass_center_x;
                s.my = mass_center_y;
                sb.note_stance(s);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || (weight_valid && weight_ready))
            quiet <= 0;
        else if (quiet >= QUIET_MAX)
        begin
            $display("watchdog: no handshake for %0d cycles", quiet);
            $display("simulation failed");
            $finish;
        end
        else
            quiet <= quiet + 1;
    end

    function automatic logic signed [COORD_BITS-1:0] crd(int v);
        return v[COORD_BITS-1:0];
    endfunction

    function automatic logic signed [COORD_BITS-1:0] any_coord();
        return COORD_BITS'($urandom);
    endfunction

    function automatic int jitter(int base, int span);
        return base + int'($urandom_range(2 * span)) - span;
    endfunction

    function automatic stance_t make(int ax, int ay, int bx, int by,
                                     int cx, int cy, int mx, int my);
        stance_t s;
        s.ax = crd(ax);
        s.ay = crd(ay);
        s.bx = crd(bx);
        s.by = crd(by);
        s.cx = crd(cx);
        s.cy = crd(cy);
        s.mx = crd(mx);
        s.my = crd(my);
        return s;
    endfunction

    function automatic stance_t random_stance();
        stance_t s;
        int      sel;
        int      px, py, ddx, ddy;
        sel = $urandom_range(99);
        px  = int'($urandom_range(800000)) - 400000;
        py  = int'($urandom_range(800000)) - 400000;
        if (sel < 35)
            s = make(any_coord(), any_coord(), any_coord(), any_coord(),
                     any_coord(), any_coord(), any_coord(), any_coord());
        else if (sel < 60)
        begin
            // feet scattered around the mass center
            s = make(jitter(px, 20000), jitter(py, 20000), jitter(px, 20000),
                     jitter(py, 20000), jitter(px, 20000), jitter(py, 20000), px, py);
        end
        else if (sel < 75)
        begin
            // feet on one line
            px  = px / 2;
            py  = py / 2;
            ddx = jitter(0, 1000);
            ddy = jitter(0, 1000);
            sel = jitter(0, 200);
            s.ax = crd(px + sel * ddx);
            s.ay = crd(py + sel * ddy);
            sel = jitter(0, 200);
            s.bx = crd(px + sel * ddx);
            s.by = crd(py + sel * ddy);
            sel = jitter(0, 200);
            s.cx = crd(px + sel * ddx);
            s.cy = crd(py + sel * ddy);
            s.mx = any_coord();
            s.my = any_coord();
        end
        else if (sel < 85)
        begin
            // tiny triangle, far mass center
            s = make(px, py, jitter(px, 2), jitter(py, 2), jitter(px, 2), jitter(py, 2),
                     0, 0);
            s.mx = any_coord();
            s.my = any_coord();
        end
        else if (sel < 95)
        begin
            s = make(px, py, jitter(0, 400000), jitter(0, 400000),
                     jitter(0, 400000), jitter(0, 400000), px, py);
            if (sel < 90)
            begin
                // mass center on the edge between the first two feet
                s.mx = crd((px + int'(s.bx)) / 2);
                s.my = crd((py + int'(s.by)) / 2);
            end
        end
        else
            s = make(px, py, px, py, px, py, any_coord(), any_coord());
        return s;
    endfunction

    function automatic int pick_gap();
        int g;
        g = 0;
        while (g < 30 && $urandom_range(99) < idle_pct)
            g++;
        return g;
    endfunction

    task automatic send_stance(stance_t s);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start         <= 1'b1;
        foot_a_x      <= s.ax;
        foot_a_y      <= s.ay;
        foot_b_x      <= s.bx;
        foot_b_y      <= s.by;
        foot_c_x      <= s.cx;
        foot_c_y      <= s.cy;
        mass_center_x <= s.mx;
        mass_center_y <= s.my;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
    endtask

    task automatic settle_pipeline();
        start <= 1'b0;
        while (sb.pending() > 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_weight(logic [WEIGHT_W-1:0] w);
        weight_valid <= 1'b1;
        body_weight  <= w;
        do
            @(posedge clk);
        while (!weight_ready);
        @(negedge clk);
        weight_valid <= 1'b0;
    endtask

    task automatic run_directed();
        send_stance(make(0, 0, 65536, 0, 0, 65536, 16384, 16384));
        send_stance(make(0, 0, 65536, 0, 0, 65536, 0, 0));
        send_stance(make(0, 0, 1000, 1000, -5000, -5000, 300, -700));
        send_stance(make(CRD_MAX, CRD_MAX, CRD_MAX, CRD_MAX, CRD_MAX, CRD_MAX, 0, 0));
        send_stance(make(CRD_MAX, CRD_MAX, CRD_MAX, CRD_MAX, CRD_MAX, CRD_MAX,
                         CRD_MAX, CRD_MAX));
        send_stance(make(CRD_MIN, CRD_MIN, CRD_MIN, CRD_MIN, CRD_MIN, CRD_MIN,
                         CRD_MIN, CRD_MIN));
        send_stance(make(CRD_MAX, CRD_MAX, CRD_MIN, CRD_MAX, 0, CRD_MIN, 0, 0));
        send_stance(make(CRD_MIN, CRD_MIN, CRD_MAX, CRD_MIN, CRD_MAX, CRD_MAX,
                         CRD_MIN, CRD_MAX));
        send_stance(make(0, 0, 1, 0, 0, 1, CRD_MIN, CRD_MIN));
        send_stance(make(0, 0, 1, 0, 0, 1, CRD_MAX, CRD_MAX));
        send_stance(make(0, 0, 0, 65536, 65536, 0, 1000, -3000));
        send_stance(make(CRD_MAX, CRD_MIN, CRD_MIN, CRD_MAX, CRD_MIN, CRD_MIN,
                         CRD_MAX, CRD_MAX));
    endtask

    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        start         = 1'b0;
        weight_valid  = 1'b0;
        body_weight   = '0;
        foot_a_x      = '0;
        foot_a_y      = '0;
        foot_b_x      = '0;
        foot_b_y      = '0;
        foot_c_x      = '0;
        foot_c_y      = '0;
        mass_center_x = '0;
        mass_center_y = '0;
        idle_pct      = 8;
        weight_writes = 0;
        quiet         = 0;
        sb            = new();

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        run_directed();
        settle_pipeline();
        write_weight(WEIGHT_W'(WEIGHT_MAX));
        run_directed();
        settle_pipeline();

        for (int seg = 0; seg < 6; seg++)
        begin
            case (seg / 2)
                0:       idle_pct = 8;
                1:       idle_pct = 60;
                default: idle_pct = 0;
            endcase
            case (seg)
                0:       write_weight(WEIGHT_W'($urandom_range(WEIGHT_MAX)));
                1:       write_weight('0);
                2:       write_weight(WEIGHT_W'(WEIGHT_MAX));
                3:       write_weight(WEIGHT_W'($urandom_range(255, 1)));
                4:       write_weight(WEIGHT_W'($urandom_range(WEIGHT_MAX)));
                default: write_weight(tcls_pkg::WEIGHT_RESET);
            endcase
            repeat (SEG_WORDS) send_stance(random_stance());
            settle_pipeline();
        end

        repeat (TOTAL_LAT + 8) @(posedge clk);
        sb.flush_leftover();
        $display("%0d tripod words, %0d results checked, %0d weight writes",
                 sb.words, sb.results, weight_writes);
        $display("%0d collinear stances, %0d saturated load sets, %0d errors",
                 sb.singular_cnt, sb.clipped_cnt, sb.errors);
        if (sb.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
